FILE: src/ucf_pkg.sv
// ----------------------------------------------------------------------------
// ucf_pkg
// Shared types, codes and helper functions of the UTF-8 case fold transform.
// ----------------------------------------------------------------------------
package ucf_pkg;

    // mode register codes, code 3 acts as lower-case only
    localparam logic [1:0] MODE_LOWER    = 2'd0;
    localparam logic [1:0] MODE_NORM     = 2'd1;
    localparam logic [1:0] MODE_TRANSLIT = 2'd2;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_REPLACE   = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_CYR_UP_LO = 21'h000410;
    localparam logic [CP_W-1:0] CP_CYR_UP_HI = 21'h00042F;
    localparam logic [CP_W-1:0] CP_CYR_YO_UP = 21'h000401;
    localparam logic [CP_W-1:0] CP_CYR_YO_LO = 21'h000451;
    localparam logic [CP_W-1:0] CP_CYR_LO_LO = 21'h000430;
    localparam logic [CP_W-1:0] CP_CYR_LO_HI = 21'h00044F;
    localparam logic [CP_W-1:0] CP_LAT_UP_LO = 21'h0000C0;
    localparam logic [CP_W-1:0] CP_LAT_UP_HI = 21'h0000DE;
    localparam logic [CP_W-1:0] CP_LAT_MUL   = 21'h0000D7;
    localparam logic [CP_W-1:0] CP_CASE_OFS  = 21'h000020;
    localparam logic [7:0]      BYTE_SPACE   = 8'h20;
    localparam logic [4:0]      LATIN_IDX_YO = 5'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DECODE,
        S_EMIT,
        S_FINISH
    } ucf_state_t;

    typedef enum logic [1:0] {
        PLAN_NONE,
        PLAN_ENC,
        PLAN_TR
    } plan_kind_t;

    typedef struct packed {
        logic take;
        logic decode;
        logic emit;
        logic finish;
    } ucf_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic go;
        logic plan_empty;
        logic more_after;
        logic step_ok;
        logic k_last;
        logic more;
        logic finish_ok;
    } ucf_sts_t;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } latin_t;

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] n;
        if (!c[7])
            n = 3'd1;
        else if (c[7:5] == 3'b110)
            n = 3'd2;
        else if (c[7:4] == 4'b1110)
            n = 3'd3;
        else if (c[7:3] == 5'b11110)
            n = 3'd4;
        else
            n = 3'd1;
        return n;
    endfunction

    function automatic logic [CP_W-1:0] lower_cp(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] r;
        r = cp;
        if (cp >= 21'h41 && cp <= 21'h5A)
            r = cp + CP_CASE_OFS;
        else if (cp >= CP_CYR_UP_LO && cp <= CP_CYR_UP_HI)
            r = cp + CP_CASE_OFS;
        else if (cp == CP_CYR_YO_UP)
            r = CP_CYR_YO_LO;
        else if (cp >= CP_LAT_UP_LO && cp <= CP_LAT_UP_HI && cp != CP_LAT_MUL)
            r = cp + CP_CASE_OFS;
        return r;
    endfunction

    function automatic logic [2:0] enc_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp <= 21'h7F)
            n = 3'd1;
        else if (cp <= 21'h7FF)
            n = 3'd2;
        else if (cp <= 21'hFFFF)
            n = 3'd3;
        else
            n = 3'd4;
        return n;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] cp, input logic [2:0] j);
        logic [2:0] n;
        logic [7:0] r;
        n = enc_len(cp);
        r = 8'h00;
        case (n)
            3'd1: r = {1'b0, cp[6:0]};
            3'd2: r = (j == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                case (j)
                    3'd0:    r = {4'b1110, cp[15:12]};
                    3'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (j)
                    3'd0:    r = {5'b11110, cp[20:18]};
                    3'd1:    r = {2'b10, cp[17:12]};
                    3'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

    // latin spelling of the lower cyrillic letters from U+0430
    function automatic latin_t latin_of(input logic [4:0] idx);
        latin_t r;
        unique case (idx)
            5'd0:  r = {2'd1, "a", 16'h0};
            5'd1:  r = {2'd1, "b", 16'h0};
            5'd2:  r = {2'd1, "v", 16'h0};
            5'd3:  r = {2'd1, "g", 16'h0};
            5'd4:  r = {2'd1, "d", 16'h0};
            5'd5:  r = {2'd1, "e", 16'h0};
            5'd6:  r = {2'd2, "zh", 8'h0};
            5'd7:  r = {2'd1, "z", 16'h0};
            5'd8:  r = {2'd1, "i", 16'h0};
            5'd9:  r = {2'd1, "y", 16'h0};
            5'd10: r = {2'd1, "k", 16'h0};
            5'd11: r = {2'd1, "l", 16'h0};
            5'd12: r = {2'd1, "m", 16'h0};
            5'd13: r = {2'd1, "n", 16'h0};
            5'd14: r = {2'd1, "o", 16'h0};
            5'd15: r = {2'd1, "p", 16'h0};
            5'd16: r = {2'd1, "r", 16'h0};
            5'd17: r = {2'd1, "s", 16'h0};
            5'd18: r = {2'd1, "t", 16'h0};
            5'd19: r = {2'd1, "u", 16'h0};
            5'd20: r = {2'd1, "f", 16'h0};
            5'd21: r = {2'd1, "h", 16'h0};
            5'd22: r = {2'd2, "ts", 8'h0};
            5'd23: r = {2'd2, "ch", 8'h0};
            5'd24: r = {2'd2, "sh", 8'h0};
            5'd25: r = {2'd3, "sch"};
            5'd26: r = {2'd0, 24'h0};
            5'd27: r = {2'd1, "y", 16'h0};
            5'd28: r = {2'd0, 24'h0};
            5'd29: r = {2'd1, "e", 16'h0};
            5'd30: r = {2'd2, "yu", 8'h0};
            5'd31: r = {2'd2, "ya", 8'h0};
        endcase
        return r;
    endfunction

endpackage

FILE: src/ucf_in_if.sv
// ----------------------------------------------------------------------------
// ucf_in_if
// Input byte channel: valid/ready handshake with raw byte and end flag.
// ----------------------------------------------------------------------------
interface ucf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_last;

    modport source (output valid, output in_byte, output string_last, input ready);
    modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface

FILE: src/ucf_out_if.sv
// ----------------------------------------------------------------------------
// ucf_out_if
// Output byte channel: valid/ready handshake with result byte and flags.
// ----------------------------------------------------------------------------
interface ucf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output string_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input string_end, output ready);
endinterface

FILE: src/ucf_ctrl.sv
// ----------------------------------------------------------------------------
// ucf_ctrl
// Sequencer: take a byte, check for a complete sequence, decode code points,
// emit their bytes and close the request.
// ----------------------------------------------------------------------------
module ucf_ctrl
    import ucf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ucf_sts_t sts,
    output ucf_cmd_t cmd
);

    ucf_state_t state_reg;
    ucf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sts.in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = sts.go ? S_DECODE : S_IDLE;
            end
            S_DECODE:
            begin
                if (!sts.plan_empty)
                    state_next = S_EMIT;
                else
                    state_next = sts.more_after ? S_DECODE : S_FINISH;
            end
            S_EMIT:
            begin
                if (sts.step_ok && sts.k_last)
                    state_next = sts.more ? S_DECODE : S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.finish_ok)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.take   = 1'b1;
            S_CHECK:  cmd        = '0;
            S_DECODE: cmd.decode = 1'b1;
            S_EMIT:   cmd.emit   = 1'b1;
            S_FINISH: cmd.finish = 1'b1;
            default:  cmd        = '0;
        endcase
    end

endmodule

FILE: src/ucf_datapath.sv
// ----------------------------------------------------------------------------
// ucf_datapath
// Byte hold buffer, code point decode, lower-casing, mode plan, byte emission
// through a one-byte look-behind stage and the output register.
// ----------------------------------------------------------------------------
module ucf_datapath
    import ucf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ucf_in_if.sink           in_ch,
    ucf_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_wdata,
    input  ucf_cmd_t         cmd,
    output ucf_sts_t         sts
);

    logic [1:0]      mode_reg;
    logic [7:0]      held_reg [4];
    logic [2:0]      held_count_reg;
    logic [2:0]      pos_reg;
    logic            last_reg;
    logic            space_pending_reg;
    logic            after_sep_reg;
    logic [CP_W-1:0] lc_reg;
    plan_kind_t      kind_reg;
    logic            space_reg;
    logic [2:0]      cnt_reg;
    logic [2:0]      k_reg;
    logic            pend_valid_reg;
    logic [7:0]      pend_byte_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_bv_reg;
    logic            out_rl_reg;
    logic            out_se_reg;

    logic            accept;
    logic [1:0]      p;
    logic [7:0]      c0;
    logic [7:0]      c1;
    logic [7:0]      c2;
    logic [7:0]      c3;
    logic [2:0]      n;
    logic            fits;
    logic [CP_W-1:0] dec_cp;
    logic [2:0]      dec_pos_next;
    logic [CP_W-1:0] lc;
    logic            alnum;
    logic            cyr_lower;
    logic [4:0]      tr_idx;
    latin_t          tr_plan;
    plan_kind_t      plan_kind;
    logic            plan_space;
    logic [2:0]      plan_cnt;
    logic            space_pending_next;
    logic            after_sep_next;

    logic [2:0]      j;
    logic [4:0]      em_idx;
    latin_t          em_latin;
    logic [7:0]      em_byte;
    logic            slot_free;
    logic            step;
    logic            fin;
    logic            load_emit;
    logic            load_fin;

    assign accept      = cmd.take & in_ch.valid;
    assign in_ch.ready = cmd.take;

    // decode the code point whose lead sits at pos
    assign p  = pos_reg[1:0];
    assign c0 = held_reg[p];
    assign c1 = held_reg[p + 2'd1];
    assign c2 = held_reg[p + 2'd2];
    assign c3 = held_reg[p + 2'd3];
    assign n  = lead_len(c0);
    assign fits = ({1'b0, pos_reg} + {1'b0, n}) <= {1'b0, held_count_reg};

    always_comb
    begin
        dec_cp       = CP_REPLACE;
        dec_pos_next = pos_reg + 3'd1;
        if (!c0[7])
        begin
            dec_cp = {13'd0, c0};
        end
        else if (n != 3'd1 && fits)
        begin
            dec_pos_next = pos_reg + n;
            case (n)
                3'd2:    dec_cp = {10'd0, c0[4:0], c1[5:0]};
                3'd3:    dec_cp = {5'd0, c0[3:0], c1[5:0], c2[5:0]};
                default: dec_cp = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
            endcase
        end
    end

    assign lc        = lower_cp(dec_cp);
    assign alnum     = (lc >= 21'h80) || (lc >= 21'h30 && lc <= 21'h39)
                       || (lc >= 21'h61 && lc <= 21'h7A);
    assign cyr_lower = (lc >= CP_CYR_LO_LO && lc <= CP_CYR_LO_HI) || (lc == CP_CYR_YO_LO);
    // offset from U+0430 in the low five bits flips bit 4
    assign tr_idx    = (lc == CP_CYR_YO_LO) ? LATIN_IDX_YO : {~lc[4], lc[3:0]};
    assign tr_plan   = latin_of(tr_idx);

    always_comb
    begin
        plan_kind          = PLAN_ENC;
        plan_space         = 1'b0;
        space_pending_next = space_pending_reg;
        after_sep_next     = after_sep_reg;
        if (mode_reg == MODE_NORM)
        begin
            if (alnum)
            begin
                plan_space         = space_pending_reg;
                space_pending_next = 1'b0;
                after_sep_next     = 1'b0;
            end
            else
            begin
                plan_kind = PLAN_NONE;
                if (!after_sep_reg)
                begin
                    space_pending_next = 1'b1;
                    after_sep_next     = 1'b1;
                end
            end
        end
        else if (mode_reg == MODE_TRANSLIT && cyr_lower)
        begin
            plan_kind = PLAN_TR;
        end
    end

    always_comb
    begin
        case (plan_kind)
            PLAN_ENC: plan_cnt = enc_len(lc) + {2'b00, plan_space};
            PLAN_TR:  plan_cnt = {1'b0, tr_plan.len};
            default:  plan_cnt = 3'd0;
        endcase
    end

    // byte k of the planned list
    assign j        = k_reg - {2'b00, space_reg};
    assign em_idx   = (lc_reg == CP_CYR_YO_LO) ? LATIN_IDX_YO : {~lc_reg[4], lc_reg[3:0]};
    assign em_latin = latin_of(em_idx);

    always_comb
    begin
        if (space_reg && k_reg == 3'd0)
            em_byte = BYTE_SPACE;
        else if (kind_reg == PLAN_TR)
        begin
            case (k_reg)
                3'd0:    em_byte = em_latin.b0;
                3'd1:    em_byte = em_latin.b1;
                default: em_byte = em_latin.b2;
            endcase
        end
        else
            em_byte = enc_byte(lc_reg, j);
    end

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign step      = cmd.emit & (!pend_valid_reg || slot_free);
    assign fin       = cmd.finish & (slot_free || (!pend_valid_reg && !last_reg));
    assign load_emit = step & pend_valid_reg;
    assign load_fin  = fin & (pend_valid_reg | last_reg);

    always_comb
    begin
        sts            = '0;
        sts.in_valid   = in_ch.valid;
        sts.go         = last_reg || (lead_len(held_reg[0]) <= held_count_reg);
        sts.plan_empty = (plan_cnt == 3'd0);
        sts.more_after = last_reg && (dec_pos_next < held_count_reg);
        sts.step_ok    = !pend_valid_reg || slot_free;
        sts.k_last     = (k_reg == cnt_reg - 3'd1);
        sts.more       = last_reg && (pos_reg < held_count_reg);
        sts.finish_ok  = slot_free || (!pend_valid_reg && !last_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_LOWER;
            held_count_reg    <= 3'd0;
            pos_reg           <= 3'd0;
            last_reg          <= 1'b0;
            space_pending_reg <= 1'b0;
            after_sep_reg     <= 1'b1;
            kind_reg          <= PLAN_NONE;
            space_reg         <= 1'b0;
            cnt_reg           <= 3'd0;
            k_reg             <= 3'd0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (accept)
            begin
                held_count_reg <= {1'b0, held_count_reg[1:0]} + 3'd1;
                last_reg       <= in_ch.string_last;
            end
            if (cmd.decode)
            begin
                pos_reg           <= dec_pos_next;
                kind_reg          <= plan_kind;
                space_reg         <= plan_space;
                cnt_reg           <= plan_cnt;
                k_reg             <= 3'd0;
                space_pending_reg <= space_pending_next;
                after_sep_reg     <= after_sep_next;
            end
            if (step)
            begin
                k_reg          <= k_reg + 3'd1;
                pend_valid_reg <= 1'b1;
            end
            if (fin)
            begin
                held_count_reg <= 3'd0;
                pos_reg        <= 3'd0;
                pend_valid_reg <= 1'b0;
                if (last_reg)
                begin
                    space_pending_reg <= 1'b0;
                    after_sep_reg     <= 1'b1;
                end
            end
            if (load_emit || load_fin)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg[held_count_reg[1:0]] <= in_ch.in_byte;
        if (cmd.decode)
            lc_reg <= lc;
        if (step)
            pend_byte_reg <= em_byte;
        if (load_emit)
        begin
            out_byte_reg <= pend_byte_reg;
            out_bv_reg   <= 1'b1;
            out_rl_reg   <= 1'b0;
            out_se_reg   <= 1'b0;
        end
        else if (load_fin)
        begin
            // with nothing pending this is the bare end marker
            out_byte_reg <= pend_valid_reg ? pend_byte_reg : 8'h00;
            out_bv_reg   <= pend_valid_reg;
            out_rl_reg   <= 1'b1;
            out_se_reg   <= last_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.byte_valid = out_bv_reg;
    assign out_ch.run_last   = out_rl_reg;
    assign out_ch.string_end = out_se_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= 3'd4)
        else $error("held byte count beyond four");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> !pend_valid_reg)
        else $error("pending byte left over at idle");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (k_reg < cnt_reg))
        else $error("emit index past planned byte count");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_bv_reg) |-> (out_rl_reg && out_se_reg && out_byte_reg == 8'h00))
        else $error("malformed end marker");

endmodule

FILE: src/utf8_case_fold_transform.sv
// ----------------------------------------------------------------------------
// utf8_case_fold_transform
// Lower-cases a UTF-8 byte stream, with optional word normalization
// (mode 1) or Cyrillic-to-Latin transliteration (mode 2). One input request
// is one raw byte; each result carries one output byte, or a bare end marker
// for a string that leaves nothing. A byte that completes a sequence emits
// up to 5 bytes; when the string ends on a cut-off sequence, each further
// code point in the held bytes is decoded and emitted in turn. The sequencer
// decodes one code point at a time and takes no new byte until it is done;
// the output register moves one byte per cycle, and a stalled output holds
// the sequencer in place.
// ----------------------------------------------------------------------------
module utf8_case_fold_transform
    import ucf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ucf_in_if.sink     in_ch,
    ucf_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    ucf_cmd_t cmd;
    ucf_sts_t sts;

    ucf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ucf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the UTF-8 case fold transform. Bytes go in through the input
// channel under random gaps; an in-bench model lower-cases, normalizes or
// transliterates each accepted request and queues the bytes it must produce.
// Every output request is checked against the oldest queued byte.
// ----------------------------------------------------------------------------
module tb_top
    import ucf_pkg::*;
();

    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam int         LIMIT_CYCLES = 200000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         MAX_OUT      = 13;
    localparam int         PHASE_BYTES  = 32;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_end;
        logic       str_end;
    } folded_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    ucf_in_if  in_ch ();
    ucf_out_if out_ch ();

    utf8_case_fold_transform uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // model state
    logic [1:0] fold_mode;
    logic [7:0] held [4];
    logic [2:0] held_n;
    logic       space_due;
    logic       sep_seen;
    int         scan_pos;
    logic [7:0] step_bytes [$];
    folded_t    folded_q [$];

    int   mismatches = 0;
    int   bytes_sent = 0;
    int   cycles = 0;
    logic calm = 1'b0;
    logic hold_off;
    logic pressure_go = 1'b0;

    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] n;
        casez (c)
            8'b0???????: n = 3'd1;
            8'b110?????: n = 3'd2;
            8'b1110????: n = 3'd3;
            8'b11110???: n = 3'd4;
            default:     n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic int utf8_count(input logic [20:0] cp);
        if (cp < 21'h80)
            return 1;
        else if (cp < 21'h800)
            return 2;
        else if (cp < 21'h10000)
            return 3;
        return 4;
    endfunction

    // encoded bytes, first byte in the top position
    function automatic logic [31:0] utf8_pack(input logic [20:0] cp);
        logic [31:0] r;
        case (utf8_count(cp))
            1: r = {1'b0, cp[6:0], 24'h0};
            2: r = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
            3: r = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
            default: r = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                          2'b10, cp[5:0]};
        endcase
        return r;
    endfunction

    function automatic string latin_text(input logic [4:0] idx);
        case (idx)
            5'd0:  return "a";
            5'd1:  return "b";
            5'd2:  return "v";
            5'd3:  return "g";
            5'd4:  return "d";
            5'd5:  return "e";
            5'd6:  return "zh";
            5'd7:  return "z";
            5'd8:  return "i";
            5'd9:  return "y";
            5'd10: return "k";
            5'd11: return "l";
            5'd12: return "m";
            5'd13: return "n";
            5'd14: return "o";
            5'd15: return "p";
            5'd16: return "r";
            5'd17: return "s";
            5'd18: return "t";
            5'd19: return "u";
            5'd20: return "f";
            5'd21: return "h";
            5'd22: return "ts";
            5'd23: return "ch";
            5'd24: return "sh";
            5'd25: return "sch";
            5'd27: return "y";
            5'd29: return "e";
            5'd30: return "yu";
            5'd31: return "ya";
            default: return "";
        endcase
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        if (step_bytes.size() < MAX_OUT)
            step_bytes.insert(step_bytes.size(), b);
    endfunction

    function automatic void append_result(input folded_t r);
        folded_q.insert(folded_q.size(), r);
    endfunction

    function automatic void put_point(input logic [20:0] cp);
        logic [31:0] seq;
        int          n;
        seq = utf8_pack(cp);
        n = utf8_count(cp);
        for (int j = 0; j < n; j++)
            put_byte(seq[31 - 8 * j -: 8]);
    endfunction

    // decode the code point that starts at scan_pos and move past it
    function automatic logic [20:0] next_point(input int len);
        int          p;
        int          n;
        logic [7:0]  c;
        logic [20:0] cp;
        p = scan_pos & 3;
        c = held[p];
        n = seq_len(c);
        if (!c[7])
        begin
            scan_pos = p + 1;
            return {13'h0, c};
        end
        if (n == 1 || p + n > len)
        begin
            scan_pos = p + 1;
            return 21'h00FFFD;
        end
        if (n == 2)
            cp = {16'h0, c[4:0]};
        else if (n == 3)
            cp = {17'h0, c[3:0]};
        else
            cp = {18'h0, c[2:0]};
        for (int k = 1; k < n; k++)
            cp = {cp[14:0], held[(p + k) & 3][5:0]};
        scan_pos = p + n;
        return cp;
    endfunction

    function automatic logic [20:0] fold_case(input logic [20:0] cp);
        if (cp >= 21'h41 && cp <= 21'h5A)
            return cp + 21'h20;
        if (cp >= 21'h410 && cp <= 21'h42F)
            return cp + 21'h20;
        if (cp == 21'h401)
            return 21'h451;
        if (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7)
            return cp + 21'h20;
        return cp;
    endfunction

    function automatic void fold_point(input logic [20:0] raw);
        logic [20:0] lc;
        logic        alnum;
        string       s;
        lc = fold_case(raw);
        if (fold_mode == MODE_NORM)
        begin
            alnum = lc >= 21'h80 || (lc >= 21'h30 && lc <= 21'h39) ||
                    (lc >= 21'h61 && lc <= 21'h7A);
            if (alnum)
            begin
                if (space_due)
                    put_byte(8'h20);
                space_due = 1'b0;
                put_point(lc);
                sep_seen = 1'b0;
            end
            else if (!sep_seen)
            begin
                space_due = 1'b1;
                sep_seen = 1'b1;
            end
        end
        else if (fold_mode == MODE_TRANSLIT &&
                 ((lc >= 21'h430 && lc <= 21'h44F) || lc == 21'h451))
        begin
            s = (lc == 21'h451) ? "e" : latin_text(lc[4:0] - 5'h10);
            for (int i = 0; i < s.len(); i++)
                put_byte(s[i]);
        end
        else
            put_point(lc);
    endfunction

    // model one accepted input request and queue the bytes it must produce
    function automatic void fold_step(input logic [7:0] b, input logic last);
        int      len;
        folded_t r;
        step_bytes.delete();
        held[held_n[1:0]] = b;
        held_n = {1'b0, held_n[1:0]} + 3'd1;
        len = int'(held_n);
        scan_pos = 0;
        if (last)
        begin
            while (scan_pos < len)
                fold_point(next_point(len));
            held_n = 3'd0;
            space_due = 1'b0;
            sep_seen = 1'b1;
        end
        else if (seq_len(held[0]) <= len)
        begin
            fold_point(next_point(len));
            held_n = 3'd0;
        end
        if (last && step_bytes.size() == 0)
            append_result({8'h00, 1'b0, 1'b1, 1'b1});
        for (int k = 0; k < step_bytes.size(); k++)
        begin
            r.data = step_bytes[k];
            r.has_byte = 1'b1;
            r.run_end = (k == step_bytes.size() - 1);
            r.str_end = r.run_end && last;
            append_result(r);
        end
    endfunction

    // ---------------- output side ----------------

    task automatic check_folded();
        folded_t want;
        folded_t got;
        got = {out_ch.out_byte, out_ch.byte_valid, out_ch.run_last, out_ch.string_end};
        if (folded_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output byte %02h valid %0b run_last %0b end %0b",
                         got.data, got.has_byte, got.run_end, got.str_end);
        end
        else
        begin
            want = folded_q.pop_front();
            if (got.data !== want.data || got.has_byte !== want.has_byte ||
                got.run_end !== want.run_end || got.str_end !== want.str_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                             want.data, want.has_byte, want.run_end, want.str_end,
                             got.data, got.has_byte, got.run_end, got.str_end);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_folded();
        out_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 32);
    end

    // long receiver hold-off, so the block fills and stalls its input
    initial
    begin
        hold_off = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("utf8_case_fold_transform regression: fail");
            $finish;
        end
    end

    // ---------------- input side ----------------

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 32)
                gap++;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.string_last <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        fold_step(b, last);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (folded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        wait_drain();
        cfg_wdata <= m;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        fold_mode = m;
    endtask

    function automatic logic [20:0] point_of_len(input int n);
        case (n)
            2: return 21'($urandom_range(21'h80, 21'h7FF));
            3: return 21'($urandom_range(21'h800, 21'hFFFF));
            default: return 21'($urandom_range(21'h10000, 21'h1FFFFF));
        endcase
    endfunction

    function automatic logic [20:0] pick_point();
        case ($urandom_range(0, 7))
            0: return 21'($urandom_range(0, 21'h7F));
            1: return 21'($urandom_range(21'h41, 21'h5A));
            2: return 21'($urandom_range(21'h400, 21'h45F));
            3: return 21'($urandom_range(21'hC0, 21'hFF));
            4: return point_of_len(2);
            5: return point_of_len(3);
            6: return point_of_len(4);
            default: return 21'($urandom_range(21'h20, 21'h2F));
        endcase
    endfunction

    task automatic send_point(input logic [20:0] cp, input logic last);
        logic [31:0] seq;
        int          n;
        seq = utf8_pack(cp);
        n = utf8_count(cp);
        for (int j = 0; j < n; j++)
            send_byte(seq[31 - 8 * j -: 8], last && j == n - 1);
    endtask

    // a multi-byte sequence cut off by the end of the string
    task automatic send_cut();
        logic [31:0] seq;
        int          n;
        int          k;
        n = $urandom_range(2, 4);
        k = $urandom_range(1, n - 1);
        seq = utf8_pack(point_of_len(n));
        for (int j = 0; j < k; j++)
            send_byte(seq[31 - 8 * j -: 8], j == k - 1);
    endtask

    // mostly well-formed points, some raw noise bytes and cut endings
    task automatic send_random_string();
        int   npts;
        int   r;
        logic tail;
        npts = $urandom_range(1, 6);
        for (int i = 0; i < npts; i++)
        begin
            tail = (i == npts - 1);
            r = $urandom_range(0, 99);
            if (r < 8)
                send_byte(8'($urandom_range(0, 255)), tail);
            else if (tail && r < 20)
                send_cut();
            else
                send_point(pick_point(), tail);
        end
    endtask

    task automatic send_until(input int target);
        while (bytes_sent < target)
            send_random_string();
    endtask

    // ---------------- tests ----------------

    task automatic test_lower_case();
        set_mode(MODE_LOWER);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hD0, 1'b0);     // capital io
        send_byte(8'h81, 1'b0);
        send_byte(8'hC3, 1'b0);     // multiplication sign stays
        send_byte(8'h97, 1'b0);
        send_byte(8'hF7, 1'b0);     // largest 4-byte value
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_bad_and_cut();
        set_mode(MODE_LOWER);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hE2, 1'b0);     // 3-byte lead cut after two bytes
        send_byte(8'h82, 1'b1);
    endtask

    task automatic test_normalize();
        set_mode(MODE_NORM);
        send_byte(8'h21, 1'b1);     // nothing left, bare end marker
        send_byte(8'h20, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h2C, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h21, 1'b1);
    endtask

    task automatic test_transliterate();
        set_mode(MODE_TRANSLIT);
        send_byte(8'hD0, 1'b0);     // capital shcha
        send_byte(8'hA9, 1'b0);
        send_byte(8'hD1, 1'b0);     // hard sign spells nothing
        send_byte(8'h8A, 1'b1);
    endtask

    task automatic test_unused_mode();
        set_mode(MODE_SPARE);
        send_byte(8'hD0, 1'b0);
        send_byte(8'h90, 1'b1);
    endtask

    task automatic test_random_modes();
        set_mode(MODE_LOWER);
        send_until(bytes_sent + PHASE_BYTES);
        set_mode(MODE_NORM);
        send_until(bytes_sent + PHASE_BYTES);
        set_mode(MODE_TRANSLIT);
        send_until(bytes_sent + PHASE_BYTES);
        set_mode(MODE_SPARE);
        send_until(bytes_sent + PHASE_BYTES);
    endtask

    task automatic test_steady_stream();
        set_mode(MODE_NORM);
        calm = 1'b1;
        send_until(bytes_sent + 30);
        wait_drain();
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        set_mode(MODE_TRANSLIT);
        calm = 1'b1;
        pressure_go = 1'b1;
        send_until(bytes_sent + 30);
        wait_drain();
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = MODE_LOWER;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.string_last = 1'b0;
        fold_mode = MODE_LOWER;
        held_n = 3'd0;
        space_due = 1'b0;
        sep_seen = 1'b1;
        for (int i = 0; i < 4; i++)
            held[i] = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_lower_case();
        test_bad_and_cut();
        test_normalize();
        test_transliterate();
        test_unused_mode();
        test_random_modes();
        test_steady_stream();
        test_backpressure();

        wait_drain();
        if (mismatches == 0)
            $display("utf8_case_fold_transform regression: pass");
        else
            $display("utf8_case_fold_transform regression: fail");
        $finish;
    end

endmodule

FILE: utf8_case_fold_transform.f
src/ucf_pkg.sv
src/ucf_in_if.sv
src/ucf_out_if.sv
src/ucf_ctrl.sv
src/ucf_datapath.sv
src/utf8_case_fold_transform.sv
sim/tb_top.sv
